/* rtl/ipcirq_pkg.sv */
package ipcirq_pkg;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CMD_W  = 2;

  // bus command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_LINK   = 20'h18003;
  localparam logic [ADDR_W-1:0] ADDR_STATUS = 20'h18020;
  localparam logic [ADDR_W-1:0] ADDR_INT    = 20'h18021;

  localparam logic [DATA_W-1:0] CMD_QUAL_BITS = 8'h0c;
  localparam logic [3:0]        LCMD_REPLY8   = 4'h1;
  localparam logic [3:0]        LCMD_VALUE    = 4'h8;
  localparam logic [3:0]        LCMD_WAIT     = 4'hd;
  localparam logic [15:0]       CMD8_VALUE    = 16'h1039;
  localparam logic [7:0]        PATTERN_HEAD  = 8'ha5;
  localparam logic [7:0]        PATTERN_ONE   = 8'h80;
  localparam logic [7:0]        STATUS_EMPTY  = 8'h02;
  localparam logic [7:0]        FRAME_CAUSE   = 8'h08;
  localparam int unsigned       FRAME_MASK_BIT = 3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LINK_WR,
    OP_MASK_WR,
    OP_STATUS_RD,
    OP_INT_RD,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [DATA_W-1:0] data;
  } entry_t;

endpackage

/* rtl/ipcirq_if.sv */
interface ipcirq_in_if;
  logic                             valid;
  logic                             ready;
  logic [ipcirq_pkg::CMD_W-1:0]     cmd;
  logic [ipcirq_pkg::ADDR_W-1:0]    addr;
  logic [ipcirq_pkg::DATA_W-1:0]    write_data;

  modport source(output valid, cmd, addr, write_data, input ready);
  modport sink(input valid, cmd, addr, write_data, output ready);
endinterface

interface ipcirq_out_if;
  logic                             valid;
  logic                             ready;
  logic [ipcirq_pkg::DATA_W-1:0]    read_data;
  logic                             irq_request;

  modport source(output valid, read_data, irq_request, input ready);
  modport sink(input valid, read_data, irq_request, output ready);
endinterface

/* rtl/ipcirq_front.sv */
module ipcirq_front (
  ipcirq_in_if.sink            in_bus,
  output logic                 push_valid,
  output ipcirq_pkg::entry_t   push_entry,
  input  logic                 push_ready
);

  ipcirq_pkg::op_t op;

  // decode bus access into a back-end operation
  always_comb begin
    op = ipcirq_pkg::OP_NOP;
    unique case (in_bus.cmd)
      ipcirq_pkg::CMD_WRITE: begin
        if (in_bus.addr == ipcirq_pkg::ADDR_LINK) begin
          op = ipcirq_pkg::OP_LINK_WR;
        end else if (in_bus.addr == ipcirq_pkg::ADDR_INT) begin
          op = ipcirq_pkg::OP_MASK_WR;
        end
      end
      ipcirq_pkg::CMD_READ: begin
        if (in_bus.addr == ipcirq_pkg::ADDR_STATUS) begin
          op = ipcirq_pkg::OP_STATUS_RD;
        end else if (in_bus.addr == ipcirq_pkg::ADDR_INT) begin
          op = ipcirq_pkg::OP_INT_RD;
        end
      end
      ipcirq_pkg::CMD_TICK: begin
        op = ipcirq_pkg::OP_TICK;
      end
      default: begin
        op = ipcirq_pkg::OP_NOP;
      end
    endcase
  end

  assign push_valid      = in_bus.valid;
  assign push_entry.op   = op;
  assign push_entry.data = in_bus.write_data;
  assign in_bus.ready    = push_ready;

endmodule

/* rtl/ipcirq_fifo.sv */
module ipcirq_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  ipcirq_pkg::entry_t   push_entry,
  output logic                 push_ready,
  output logic                 pop_valid,
  output ipcirq_pkg::entry_t   pop_entry,
  input  logic                 pop_ready
);

  ipcirq_pkg::entry_t mem_r [ipcirq_pkg::QUEUE_DEPTH];
  logic [ipcirq_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ipcirq_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ipcirq_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic push, pop;

  assign push_ready = (count_r != ipcirq_pkg::QCNT_W'(ipcirq_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ipcirq_pkg::QPTR_W'(ipcirq_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ipcirq_pkg::QPTR_W'(ipcirq_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + ipcirq_pkg::QCNT_W'(push) - ipcirq_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ipcirq_pkg::QCNT_W'(ipcirq_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointer gap");
`endif

endmodule

/* rtl/ipcirq_back.sv */
module ipcirq_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  input  ipcirq_pkg::entry_t   pop_entry,
  output logic                 pop_ready,
  ipcirq_out_if.source         out_bus
);

  logic        waiting_r, waiting_nxt;
  logic [4:0]  shift_r, shift_nxt;
  logic [15:0] reply_r, reply_nxt;
  logic [4:0]  bits_left_r, bits_left_nxt;
  logic [23:0] pattern_r, pattern_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [7:0]  cause_r, cause_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        irq_r, irq_nxt;

  logic        pop;
  logic [4:0]  shift_in;
  logic [4:0]  bits_dec;
  logic        reply_bit;
  logic [23:0] pattern_sh;

  // output register frees when empty or taken this cycle
  assign pop_ready = !out_valid_r || out_bus.ready;
  assign pop       = pop_valid && pop_ready;

  assign shift_in   = {shift_r[3:0], (pop_entry.data != ipcirq_pkg::CMD_QUAL_BITS)};
  assign bits_dec   = bits_left_r - 5'd1;
  assign reply_bit  = !bits_dec[4] && reply_r[bits_dec[3:0]];
  assign pattern_sh = {8'h00, pattern_r[23:8]};

  always_comb begin
    waiting_nxt   = waiting_r;
    shift_nxt     = shift_r;
    reply_nxt     = reply_r;
    bits_left_nxt = bits_left_r;
    pattern_nxt   = pattern_r;
    mask_nxt      = mask_r;
    cause_nxt     = cause_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    rd_nxt        = rd_r;
    irq_nxt       = irq_r;

    if (pop) begin
      out_valid_nxt = 1'b1;
      rd_nxt        = '0;
      irq_nxt       = 1'b0;
      unique case (pop_entry.op)
        ipcirq_pkg::OP_LINK_WR: begin
          if (waiting_r) begin
            if ((pop_entry.data & ipcirq_pkg::CMD_QUAL_BITS) == ipcirq_pkg::CMD_QUAL_BITS) begin
              shift_nxt = shift_in;
              if (shift_in[4]) begin
                shift_nxt   = 5'd1;
                waiting_nxt = 1'b0;
                unique case (shift_in[3:0])
                  ipcirq_pkg::LCMD_REPLY8: begin
                    reply_nxt     = '0;
                    bits_left_nxt = 5'd8;
                  end
                  // returns to waiting as the wait case does: no reply bits go out
                  ipcirq_pkg::LCMD_VALUE: begin
                    reply_nxt     = ipcirq_pkg::CMD8_VALUE;
                    bits_left_nxt = 5'd16;
                    waiting_nxt   = 1'b1;
                  end
                  ipcirq_pkg::LCMD_WAIT: begin
                    waiting_nxt = 1'b1;
                  end
                  default: begin
                    reply_nxt     = '0;
                    bits_left_nxt = 5'd4;
                  end
                endcase
              end
            end
          end else begin
            bits_left_nxt = bits_dec;
            pattern_nxt   = {ipcirq_pkg::PATTERN_HEAD,
                             reply_bit ? ipcirq_pkg::PATTERN_ONE : 8'h00, 8'h00};
            if (bits_dec == '0) begin
              waiting_nxt = 1'b1;
            end
          end
        end
        ipcirq_pkg::OP_MASK_WR: begin
          mask_nxt = pop_entry.data;
        end
        ipcirq_pkg::OP_STATUS_RD: begin
          if (pattern_r == '0) begin
            rd_nxt = ipcirq_pkg::STATUS_EMPTY;
          end else begin
            rd_nxt      = pattern_r[7:0];
            pattern_nxt = (pattern_sh == {16'h0000, ipcirq_pkg::PATTERN_HEAD}) ?
                          '0 : pattern_sh;
          end
        end
        ipcirq_pkg::OP_INT_RD: begin
          rd_nxt    = cause_r;
          cause_nxt = '0;
        end
        ipcirq_pkg::OP_TICK: begin
          if (mask_r[ipcirq_pkg::FRAME_MASK_BIT]) begin
            cause_nxt = ipcirq_pkg::FRAME_CAUSE;
            mask_nxt[ipcirq_pkg::FRAME_MASK_BIT] = 1'b0;
            irq_nxt   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r   <= 1'b1;
      shift_r     <= 5'd1;
      reply_r     <= '0;
      bits_left_r <= '0;
      pattern_r   <= '0;
      mask_r      <= '0;
      cause_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      waiting_r   <= waiting_nxt;
      shift_r     <= shift_nxt;
      reply_r     <= reply_nxt;
      bits_left_r <= bits_left_nxt;
      pattern_r   <= pattern_nxt;
      mask_r      <= mask_nxt;
      cause_r     <= cause_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r  <= rd_nxt;
    irq_r <= irq_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.read_data   = rd_r;
  assign out_bus.irq_request = irq_r;

`ifndef NO_ASSERTIONS
  a_pattern_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (pattern_r == '0) || (pattern_r[23:16] == ipcirq_pkg::PATTERN_HEAD) ||
    (pattern_r[23:8] == {8'h00, ipcirq_pkg::PATTERN_HEAD}))
    else $error("read pattern out of shape");

  a_shift_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (shift_r != '0) && !shift_r[4])
    else $error("command shift lost its marker");

  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && irq_r) |-> (rd_r == '0))
    else $error("interrupt word carries read data");

  a_tick_clears_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_entry.op == ipcirq_pkg::OP_TICK) |=>
    !mask_r[ipcirq_pkg::FRAME_MASK_BIT])
    else $error("frame mask bit left set after tick");

  a_irq_sets_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && irq_nxt) |=> (cause_r == ipcirq_pkg::FRAME_CAUSE))
    else $error("frame interrupt without cause");
`endif

endmodule

/* rtl/ipc_link_and_interrupt_regs_core.sv */
// channel   dir  word                              handshake
// in_bus    in   cmd, addr, write_data             valid/ready
// out_bus   out  read_data, irq_request            valid/ready
//
// one word in and one word out per cycle while out_bus is ready; a word taken
// from in_bus is written into the decode queue, then the execute stage
// updates the link and interrupt state and loads the result register,
// which drives out_bus
// rst_n is synchronous: the queue empties and all state but the result data and irq registers returns to idle
// out_bus stalls hold the result register; in_bus keeps taking words until
// the two-entry queue is full

module ipc_link_and_interrupt_regs_core (
  input  logic         clk,
  input  logic         rst_n,
  ipcirq_in_if.sink    in_bus,
  ipcirq_out_if.source out_bus
);

  logic               push_valid, push_ready;
  ipcirq_pkg::entry_t push_entry;
  logic               pop_valid, pop_ready;
  ipcirq_pkg::entry_t pop_entry;

  ipcirq_front u_front (
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  ipcirq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  ipcirq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_bus   (out_bus)
  );

endmodule
